// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication or expression on every clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that a condition never holds out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/dsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// DLE/STX frame encoder package
// Line symbols, queue sizing, work descriptor and sequencer phase helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dsfe_pkg;

	localparam logic [7:0] SYM_DLE = 8'h10;
	localparam logic [7:0] SYM_STX = 8'h02;
	localparam logic [7:0] SYM_ETX = 8'h03;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;
	localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0] data;
		logic       hdr;
		logic       stuff;
		logic       last;
		logic [7:0] bcc;
	} dsfe_desc_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_HDR_DLE,
		PH_HDR_STX,
		PH_STUFF,
		PH_DATA,
		PH_TRL_DLE,
		PH_TRL_ETX,
		PH_TRL_BCC
	} dsfe_phase_t;

	function automatic dsfe_phase_t first_phase(input dsfe_desc_t d);
		dsfe_phase_t ph;
		if (d.hdr) begin
			ph = PH_HDR_DLE;
		end else if (d.stuff) begin
			ph = PH_STUFF;
		end else begin
			ph = PH_DATA;
		end
		return ph;
	endfunction

	function automatic dsfe_phase_t next_phase(input dsfe_desc_t d, input dsfe_phase_t ph);
		dsfe_phase_t nx;
		unique case (ph)
			PH_HDR_DLE: nx = PH_HDR_STX;
			PH_HDR_STX: nx = d.stuff ? PH_STUFF : PH_DATA;
			PH_STUFF:   nx = PH_DATA;
			PH_DATA:    nx = d.last ? PH_TRL_DLE : PH_START;
			PH_TRL_DLE: nx = PH_TRL_ETX;
			PH_TRL_ETX: nx = PH_TRL_BCC;
			default:    nx = PH_START;
		endcase
		return nx;
	endfunction

	function automatic logic [7:0] phase_byte(input dsfe_desc_t d, input dsfe_phase_t ph);
		logic [7:0] b;
		unique case (ph)
			PH_HDR_STX: b = SYM_STX;
			PH_DATA:    b = d.data;
			PH_TRL_ETX: b = SYM_ETX;
			PH_TRL_BCC: b = d.bcc;
			default:    b = SYM_DLE;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dle_stx_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// DLE/STX frame encoder
// Byte-stuffing serial framer with DLE STX header, DLE ETX trailer and XOR BCC.
// ----------------------------------------------------------------------------
// Each input item is one payload byte; tlast marks the last byte of a frame.
// The output sends one line byte per cycle while the sink is ready and work is
// queued. An item yields one to seven line bytes: a DLE STX header on the first
// byte of a frame, a doubled DLE for a payload DLE, and a DLE ETX BCC trailer
// after the last byte. The front end takes an item every cycle while its
// four-entry descriptor queue has room, so short bursts enter at full rate;
// the sustained rate is set by the output sequencer at one line byte per ready
// cycle: one line byte per plain payload byte, two per stuffed byte, plus two
// per frame for the header and three for the trailer. The first line byte of
// an item passes through the queue and then the output register to the output.
`default_nettype none

module dle_stx_frame_encoder
	import dsfe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,   // last_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] line_byte
	output logic            m_tlast,   // end_of_run
	output logic            m_tuser    // end_of_frame
);

	logic       q_push;
	logic       q_ready;
	logic       q_pop;
	logic       q_valid;
	dsfe_desc_t q_desc;
	dsfe_desc_t q_head;

	dsfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_ready  (q_ready),
		.q_push   (q_push),
		.q_desc   (q_desc)
	);

	dsfe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_desc),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	dsfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/dsfe_front.sv -----
// ----------------------------------------------------------------------------
// DLE/STX frame encoder front end
// Accepts payload items, tracks frame state and BCC, builds work descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfe_front
	import dsfe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,   // last_byte
	input  wire logic       q_ready,
	output logic            q_push,
	output dsfe_desc_t      q_desc
);

	logic       open_q;
	logic [7:0] bcc_q;
	logic [7:0] bcc_next;

	assign s_tready = q_ready;
	assign q_push   = s_tvalid && q_ready;
	assign bcc_next = (open_q ? bcc_q : 8'h00) ^ s_tdata;

	always_comb begin
		q_desc.data  = s_tdata;
		q_desc.hdr   = !open_q;
		q_desc.stuff = (s_tdata == SYM_DLE);
		q_desc.last  = s_tlast;
		q_desc.bcc   = bcc_next ^ SYM_ETX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			bcc_q  <= 8'h00;
		end else if (q_push) begin
			if (s_tlast) begin
				open_q <= 1'b0;
				bcc_q  <= 8'h00;
			end else begin
				open_q <= 1'b1;
				bcc_q  <= bcc_next;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dsfe_fifo.sv -----
// ----------------------------------------------------------------------------
// DLE/STX frame encoder descriptor queue
// Short first-in first-out queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfe_fifo
	import dsfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire dsfe_desc_t  push_desc,
	output logic             ready,
	input  wire logic        pop,
	output logic             valid,
	output dsfe_desc_t       head
);

	dsfe_desc_t                 mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]     wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]     rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]     count_q;

	assign ready = (count_q != QUEUE_FULL);
	assign valid = (count_q != '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dsfe_back.sv -----
// ----------------------------------------------------------------------------
// DLE/STX frame encoder back end
// Steps through each descriptor, sending one line byte per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfe_back
	import dsfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire dsfe_desc_t  q_head,
	output logic             q_pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] line_byte
	output logic             m_tlast,   // end_of_run
	output logic             m_tuser    // end_of_frame
);

	dsfe_phase_t phase_q;
	dsfe_phase_t phase_d;
	dsfe_phase_t cur_ph;
	dsfe_phase_t nxt_ph;
	logic        load;
	logic        tvalid_q;
	logic [7:0]  tdata_q;
	logic        tlast_q;
	logic        tuser_q;

	always_comb begin
		cur_ph  = (phase_q == PH_START) ? first_phase(q_head) : phase_q;
		nxt_ph  = next_phase(q_head, cur_ph);
		load    = q_valid && (!tvalid_q || m_tready);
		q_pop   = load && (nxt_ph == PH_START);
		phase_d = load ? nxt_ph : phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			tvalid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (load) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tdata_q <= phase_byte(q_head, cur_ph);
			tlast_q <= (nxt_ph == PH_START);
			tuser_q <= (cur_ph == PH_TRL_BCC);
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;
	assign m_tuser  = tuser_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dsfe_checker.sv -----
// ----------------------------------------------------------------------------
// DLE/STX frame encoder checker
// Port-level assertions on the encoded line stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dsfe_checker
	import dsfe_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast,
	input wire logic       m_tuser
);

	`ASSERT_NEVER(a_bcc_ends_run, clk, arst_n, m_tvalid && m_tuser && !m_tlast, "BCC byte without end of run")
	`ASSERT_IMPL(a_frame_restarts_dle, clk, arst_n, (m_tvalid && m_tready && m_tuser) ##1 m_tvalid |-> m_tdata == SYM_DLE, "new frame does not open with DLE")
	`ASSERT_IMPL(a_stall_holds, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled output item changed")

endmodule

bind dle_stx_frame_encoder dsfe_checker u_checker (.*);

`default_nettype wire
